[rtl/gf128_keyed_multiply_macros.svh]
// ----------------------------------------------------------------------------
// gf128_keyed_multiply assertion macros
// Concurrent check wrappers, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GF128_KEYED_MULTIPLY_MACROS_SVH
`define GF128_KEYED_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GKM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gf128 keyed multiply check failed");
// next-cycle implication
`define GKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gf128 keyed multiply check failed");
`else
`define GKM_ASSERT_IMPL(lbl, ante, cons)
`define GKM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/gf128km_pkg.sv]
// ----------------------------------------------------------------------------
// gf128km_pkg
// Shared types, register indexes and GF(2^128) helpers (reflected bit order).
// ----------------------------------------------------------------------------
`default_nettype none

package gf128km_pkg;

    localparam int ELEM_W      = 128;
    localparam int HALF_W      = 64;
    localparam int CFG_INDEX_W = 8;

    typedef logic [ELEM_W-1:0]      gf_elem_t;
    typedef logic [HALF_W-1:0]      gf_half_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_KEY_LOW  = 8'd0;
    localparam cfg_index_t REG_KEY_HIGH = 8'd1;

    // reduction byte, lands in bits 127..120 after a shift
    localparam logic [7:0] RED_BYTE = 8'hE1;

    typedef struct packed {
        logic main_valid;
        logic spare_valid;
        logic main_ready;
    } skid_status_t;

    // multiply by x: shift right, fold the dropped bit back in
    function automatic gf_elem_t times_x(input gf_elem_t v);
        gf_elem_t r;
        r = v >> 1;
        if (v[0]) begin
            r[ELEM_W-1 -: 8] = r[ELEM_W-1 -: 8] ^ RED_BYTE;
        end
        return r;
    endfunction

    function automatic gf_elem_t bit_rev(input gf_elem_t v);
        gf_elem_t r;
        for (int i = 0; i < ELEM_W; i++) begin
            r[i] = v[ELEM_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/gf128km_skid.sv]
// ----------------------------------------------------------------------------
// gf128km_skid
// Two-entry input buffer; registered ready, holds the operand for the multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module gf128km_skid (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire gf128km_pkg::gf_elem_t    in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output gf128km_pkg::gf_elem_t         out_data,
    output gf128km_pkg::skid_status_t     status
);

    logic                  main_valid_reg, main_valid_next;
    logic                  spare_valid_reg, spare_valid_next;
    gf128km_pkg::gf_elem_t main_reg, main_next;
    gf128km_pkg::gf_elem_t spare_reg, spare_next;
    logic                  accept;
    logic                  main_free;

    assign in_ready  = !spare_valid_reg;
    assign accept    = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;

    always_comb begin
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        main_next        = main_reg;
        spare_next       = spare_reg;
        if (main_free) begin
            if (spare_valid_reg) begin
                main_valid_next  = 1'b1;
                main_next        = spare_reg;
                spare_valid_next = 1'b0;
            end else begin
                main_valid_next = accept;
                main_next       = in_data;
            end
        end else if (accept) begin
            spare_valid_next = 1'b1;
            spare_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

    assign out_valid          = main_valid_reg;
    assign out_data           = main_reg;
    assign status.main_valid  = main_valid_reg;
    assign status.spare_valid = spare_valid_reg;
    assign status.main_ready  = out_ready;

endmodule

`default_nettype wire

[rtl/gf128km_mult.sv]
// ----------------------------------------------------------------------------
// gf128km_mult
// Single-pass product operand * H * x: carry-less multiply, then reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module gf128km_mult (
    input  wire gf128km_pkg::gf_elem_t key,
    input  wire gf128km_pkg::gf_elem_t operand,
    output gf128km_pkg::gf_elem_t      product
);

    localparam int W  = gf128km_pkg::ELEM_W;
    localparam int CW = 2 * W - 1;

    gf128km_pkg::gf_elem_t g;
    gf128km_pkg::gf_elem_t a;
    gf128km_pkg::gf_elem_t b;
    logic [CW-1:0]         c;
    logic [W-2:0]          h;
    logic [W+5:0]          t;
    logic [5:0]            o;
    logic [12:0]           u;
    gf128km_pkg::gf_elem_t r;

    // work in the normal polynomial order: bit k is the coefficient of x^k
    assign g = gf128km_pkg::times_x(key);
    assign a = gf128km_pkg::bit_rev(operand);
    assign b = gf128km_pkg::bit_rev(g);

    // carry-less product, one XOR tree per output bit
    always_comb begin
        c = '0;
        for (int k = 0; k < CW; k++) begin
            for (int i = 0; i < W; i++) begin
                if (k >= i && k - i < W) begin
                    c[k] = c[k] ^ (a[i] & b[k-i]);
                end
            end
        end
    end

    // fold x^128 = x^7 + x^2 + x + 1, twice
    assign h = c[CW-1:W];
    assign t = {7'b0, h} ^ {6'b0, h, 1'b0} ^ {5'b0, h, 2'b0} ^ {h, 7'b0};
    assign o = t[W+5:W];
    assign u = {7'b0, o} ^ {6'b0, o, 1'b0} ^ {5'b0, o, 2'b0} ^ {o, 7'b0};
    assign r = c[W-1:0] ^ t[W-1:0] ^ {{(W-13){1'b0}}, u};

    assign product = gf128km_pkg::bit_rev(r);

endmodule

`default_nettype wire

[rtl/gf128_keyed_multiply.sv]
// ----------------------------------------------------------------------------
// gf128_keyed_multiply
// GF(2^128) multiply of a streamed operand by a configured key H (times x).
// ----------------------------------------------------------------------------
// Path: the input beat enters the buffer's operand register, then the result register.
// Throughput: 1 beat per cycle while m_tready keeps the result register draining; one full
// multiply sits between the buffered operand register and the result register.
// Reset (synchronous, active low): key cleared to zero, buffers emptied.
// Key writes are taken every cycle (cfg_ready is tied high).
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf128_keyed_multiply_macros.svh"

module gf128_keyed_multiply (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // operand stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [127:0]                  s_tdata,   // operand_low, operand_high
    // product stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [127:0]                       m_tdata,   // product_low, product_high
    // key register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire gf128km_pkg::cfg_index_t       cfg_index,
    input  wire logic [63:0]                   cfg_data
);

    // key registers, H = {key_high, key_low}
    gf128km_pkg::gf_half_t key_low_reg, key_high_reg;

    // operand buffer toward the multiplier
    logic                      op_valid;
    logic                      op_ready;
    gf128km_pkg::gf_elem_t     op_data;
    gf128km_pkg::skid_status_t skid_status;

    // result register
    logic                      result_valid_reg;
    gf128km_pkg::gf_elem_t     product_reg;
    gf128km_pkg::gf_elem_t     product;

    // buffer conditions seen by the checks
    logic                      beat_in;
    logic                      main_stalled;
    logic                      op_moves;

    assign cfg_ready = 1'b1;

    // unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gf128km_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                gf128km_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // two-entry buffer keeps s_tready registered, off the m_tready path
    gf128km_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (op_valid),
        .out_ready (op_ready),
        .out_data  (op_data),
        .status    (skid_status)
    );

    gf128km_mult u_mult (
        .key     ({key_high_reg, key_low_reg}),
        .operand (op_data),
        .product (product)
    );

    // result register advances whenever empty or being drained
    assign op_ready = !result_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (op_ready) begin
            result_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_ready) begin
            product_reg <= product;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = product_reg;

    assign beat_in      = s_tvalid && s_tready;
    assign main_stalled = skid_status.main_valid && !skid_status.main_ready;
    assign op_moves     = skid_status.main_valid && skid_status.main_ready;

    // spare entry is only used behind a held main entry
    `GKM_ASSERT_IMPL(a_spare_behind_main, skid_status.spare_valid, skid_status.main_valid)
    // a beat arriving while the main entry stalls lands in the spare entry
    `GKM_ASSERT_NEXT(a_stall_fills_spare, beat_in && main_stalled, skid_status.spare_valid)
    // a buffered operand that moves on always shows up as a result
    `GKM_ASSERT_NEXT(a_operand_to_result, op_moves, m_tvalid)

endmodule

`default_nettype wire

[tb/gf128_keyed_multiply_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf128_keyed_multiply_checker
// Tracks key writes, predicts the product for every operand beat and
// compares each product beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gf128_keyed_multiply_checker
    import gf128km_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  gf_elem_t   s_tdata,     // operand_low, operand_high
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  gf_elem_t   m_tdata,     // product_low, product_high
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  gf_half_t   cfg_data,
    output int         mismatch_count,
    output int         pending_products
);

    localparam int       REPORT_LIMIT   = 10;
    // 0xE1 folded into the top byte after a right shift
    localparam gf_elem_t REDUCTION_TERM = {8'hE1, 120'd0};

    gf_half_t key_lo;
    gf_half_t key_hi;
    gf_elem_t expected_products[$];
    int       error_tally = 0;

    function automatic gf_elem_t mul_by_x(input gf_elem_t v);
        return (v >> 1) ^ (v[0] ? REDUCTION_TERM : '0);
    endfunction

    function automatic gf_elem_t keyed_product(input gf_elem_t key, input gf_elem_t operand);
        gf_elem_t g;
        gf_elem_t acc;
        g   = mul_by_x(key);
        acc = '0;
        // operand bit j ends up with 127-j more factors of x
        for (int j = 0; j < ELEM_W; j++) begin
            acc = mul_by_x(acc);
            if (operand[j]) begin
                acc = acc ^ g;
            end
        end
        return acc;
    endfunction

    always @(posedge aclk) begin : watch
        gf_elem_t want;
        if (!aresetn) begin
            key_lo = '0;
            key_hi = '0;
            expected_products.delete();
        end else begin
            // product side first, so a same-edge operand beat can't hide a stray result
            if (m_tvalid && m_tready) begin
                if (expected_products.size() == 0) begin
                    if (error_tally < REPORT_LIMIT) begin
                        $display("%0t: product beat %h with nothing outstanding",
                                 $realtime, m_tdata);
                    end
                    error_tally++;
                end else begin
                    want = expected_products.pop_front();
                    if (m_tdata[HALF_W-1:0] !== want[HALF_W-1:0]) begin
                        if (error_tally < REPORT_LIMIT) begin
                            $display("%0t: product_low expected %h got %h",
                                     $realtime, want[HALF_W-1:0], m_tdata[HALF_W-1:0]);
                        end
                        error_tally++;
                    end
                    if (m_tdata[ELEM_W-1:HALF_W] !== want[ELEM_W-1:HALF_W]) begin
                        if (error_tally < REPORT_LIMIT) begin
                            $display("%0t: product_high expected %h got %h",
                                     $realtime, want[ELEM_W-1:HALF_W],
                                     m_tdata[ELEM_W-1:HALF_W]);
                        end
                        error_tally++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_products.push_back(keyed_product({key_hi, key_lo}, s_tdata));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_LOW:  key_lo = cfg_data;
                    REG_KEY_HIGH: key_hi = cfg_data;
                    default: ;  // unmapped index, dropped
                endcase
            end
        end
        pending_products <= expected_products.size();
        mismatch_count   <= error_tally;
    end

endmodule

[tb/gf128_keyed_multiply_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf128_keyed_multiply_test
// Streams operands through the keyed GF(2^128) multiplier under a series of
// keys (zero, one, all ones, top bit only, low half all ones, random) and lets the checker
// compare every product beat. Handshakes are throttled in three phases:
// light sender gaps with heavy backpressure, the reverse, then full rate.
// ----------------------------------------------------------------------------
module gf128_keyed_multiply_test;

    import gf128km_pkg::*;

    localparam int         RESET_CYCLES  = 8;
    localparam int         SETTLE_CYCLES = 4;      // padding after the outstanding products drain
    localparam int         ITEMS_PER_KEY = 208;    // 3 phases x 2 keys x 208 beats
    localparam realtime    TIMEOUT_NS    = 10_000_000.0;
    localparam cfg_index_t REG_UNMAPPED  = 8'hA5;  // no register lives here
    localparam gf_half_t   ALL_ONES      = '1;
    localparam gf_half_t   TOP_BIT       = 64'h8000_0000_0000_0000;
    localparam gf_half_t   BOTTOM_BIT    = 64'd1;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    gf_elem_t   s_tdata   = '0;     // operand_low [63:0], operand_high [127:64]
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    gf_elem_t   m_tdata;            // product_low [63:0], product_high [127:64]
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_KEY_LOW;
    gf_half_t   cfg_data  = '0;

    // percent of cycles each side sits out
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    int mismatch_count;
    int pending_products;

    always #10 aclk = ~aclk;

    gf128_keyed_multiply uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gf128_keyed_multiply_checker product_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_products (pending_products)
    );

    // backpressure: redraw tready every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // one operand beat; tvalid stays up across back-to-back beats
    task automatic send_operand(input gf_elem_t operand);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= operand;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // leaves cfg_valid high; caller drops it
    task automatic write_reg(input cfg_index_t index, input gf_half_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
    endtask

    task automatic load_key(input gf_half_t key_hi, input gf_half_t key_lo);
        write_reg(REG_KEY_LOW, key_lo);
        write_reg(REG_KEY_HIGH, key_hi);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and let every outstanding product drain out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_products != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        gf_elem_t operand;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct   = 6;
        receiver_idle_pct = 76;

        // key still at its reset value of zero: every product is zero
        send_operand('1);
        send_operand({$urandom, $urandom, $urandom, $urandom});

        // H = 1: zero operand, lone end bits, all ones, the limb seam
        settle();
        load_key('0, BOTTOM_BIT);
        send_operand('0);
        send_operand({64'd0, BOTTOM_BIT});
        send_operand({TOP_BIT, 64'd0});
        send_operand('1);
        send_operand({BOTTOM_BIT, TOP_BIT});

        // write to an unmapped index must leave H = 1 in place
        settle();
        write_reg(REG_UNMAPPED, ALL_ONES);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        send_operand('1);
        send_operand({64'd0, BOTTOM_BIT});

        // all-ones key, heavy reduction
        settle();
        load_key(ALL_ONES, ALL_ONES);
        send_operand('0);
        send_operand('1);
        send_operand({64'd0, BOTTOM_BIT});
        send_operand({TOP_BIT, 64'd0});
        send_operand({64'd0, ALL_ONES});

        // key with only bit 127: the times-x step just shifts it down to bit 126
        settle();
        load_key(TOP_BIT, '0);
        send_operand('1);
        send_operand({64'd0, BOTTOM_BIT});
        send_operand({TOP_BIT, 64'd0});
        send_operand({$urandom, $urandom, $urandom, $urandom});

        // random part: two keys per throttle phase
        for (int phase = 0; phase < 3; phase++) begin
            for (int k = 0; k < 2; k++) begin
                settle();
                case (phase)
                    0: begin
                        sender_idle_pct   = 6;
                        receiver_idle_pct = 76;
                    end
                    1: begin
                        sender_idle_pct   = 76;
                        receiver_idle_pct = 6;
                    end
                    default: begin
                        sender_idle_pct   = 0;
                        receiver_idle_pct = 0;
                    end
                endcase
                if (phase == 2 && k == 1) begin
                    load_key('0, ALL_ONES);
                end else begin
                    load_key({$urandom, $urandom}, {$urandom, $urandom});
                end
                repeat (ITEMS_PER_KEY) begin
                    operand = {$urandom, $urandom, $urandom, $urandom};
                    // a few sparse and degenerate operands mixed in
                    case ($urandom_range(0, 15))
                        0: operand = '0;
                        1: operand = '1;
                        2: operand = gf_elem_t'(1) << $urandom_range(0, ELEM_W - 1);
                        3: operand = operand & {$urandom, $urandom, $urandom, $urandom};
                        default: ;
                    endcase
                    send_operand(operand);
                end
            end
        end

        settle();
        if (mismatch_count == 0 && pending_products == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/gf128km_pkg.sv
rtl/gf128km_skid.sv
rtl/gf128km_mult.sv
rtl/gf128_keyed_multiply.sv
tb/gf128_keyed_multiply_checker.sv
tb/gf128_keyed_multiply_test.sv
